// ===== hw/rtl/tnis_pkg.sv =====
// ----------------------------------------------------------------------------
// tnis_pkg
// Shared types and constants for the top-N insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package tnis_pkg;

	localparam int KEEP_COUNT = 8;
	localparam int CNT_W      = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

	localparam int PT_W   = 16;
	localparam int ETA_W  = 9;
	localparam int PHI_W  = 10;
	localparam int KIND_W = 4;
	localparam int Z0_W   = 10;

	typedef struct packed {
		logic [PT_W-1:0]   obj_pt;
		logic [ETA_W-1:0]  obj_eta;
		logic [PHI_W-1:0]  obj_phi;
		logic [KIND_W-1:0] obj_kind;
		logic [Z0_W-1:0]   obj_z0;
		logic              set_end;
	} obj_t;

	typedef struct packed {
		logic [PT_W-1:0]   out_pt;
		logic [ETA_W-1:0]  out_eta;
		logic [PHI_W-1:0]  out_phi;
		logic [KIND_W-1:0] out_kind;
		logic [Z0_W-1:0]   out_z0;
		logic              out_last;
	} res_t;

	// one stored rank
	typedef struct packed {
		logic [PT_W-1:0]   pt;
		logic [ETA_W-1:0]  eta;
		logic [PHI_W-1:0]  phi;
		logic [KIND_W-1:0] kind;
		logic [Z0_W-1:0]   z0;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic insert;   // insert the incoming item into the ranks
		logic load;     // move rank 0 to the output register, shift ranks up
		logic last;     // the item loaded is the final one of the set
	} cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tnis_datapath.sv =====
// ----------------------------------------------------------------------------
// tnis_datapath
// Rank cells with parallel compare-and-shift insert, drain shift and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tnis_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tnis_pkg::cmd_t cmd,
	input  wire tnis_pkg::obj_t in_data,
	output tnis_pkg::res_t     out_data
);
	import tnis_pkg::*;

	entry_t                 rank_q [KEEP_COUNT];
	entry_t                 rank_d [KEEP_COUNT];
	logic [KEEP_COUNT-1:0]  take;
	entry_t                 item;
	res_t                   out_q;

	assign item = '{pt: in_data.obj_pt, eta: in_data.obj_eta, phi: in_data.obj_phi,
		kind: in_data.obj_kind, z0: in_data.obj_z0};

	// ranks are sorted descending, so take[] is a run of zeros then ones
	always_comb begin
		for (int i = 0; i < KEEP_COUNT; i++) begin
			take[i] = (rank_q[i].pt <= item.pt);
		end
	end

	always_comb begin
		for (int i = 0; i < KEEP_COUNT; i++) begin
			rank_d[i] = rank_q[i];
			if (cmd.load) begin
				if (i == KEEP_COUNT - 1) begin
					rank_d[i] = '0;
				end else begin
					rank_d[i] = rank_q[(i + 1) % KEEP_COUNT];
				end
			end else if (cmd.insert && take[i]) begin
				if (i == 0) begin
					rank_d[i] = item;
				end else if (!take[(i + KEEP_COUNT - 1) % KEEP_COUNT]) begin
					rank_d[i] = item;
				end else begin
					rank_d[i] = rank_q[(i + KEEP_COUNT - 1) % KEEP_COUNT];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEEP_COUNT; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < KEEP_COUNT; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= '{out_pt: rank_q[0].pt, out_eta: rank_q[0].eta,
				out_phi: rank_q[0].phi, out_kind: rank_q[0].kind,
				out_z0: rank_q[0].z0, out_last: cmd.last};
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tnis_ctrl.sv =====
// ----------------------------------------------------------------------------
// tnis_ctrl
// Fill/drain controller: accepts items, then unloads all ranks on set end.
// ----------------------------------------------------------------------------
`default_nettype none

module tnis_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_set_end,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	output tnis_pkg::cmd_t      cmd
);
	import tnis_pkg::*;

	localparam logic ST_FILL  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             load;
	logic             at_last;

	assign in_stall = (state_q == ST_DRAIN);
	assign accept   = in_valid && !in_stall;
	assign at_last  = (cnt_q == CNT_W'(KEEP_COUNT - 1));
	assign load     = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall);

	assign cmd.insert = accept;
	assign cmd.load   = load;
	assign cmd.last   = at_last;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (accept && in_set_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load) begin
						if (at_last) begin
							state_q <= ST_FILL;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_drain_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> in_stall)
		else $error("input taken during drain");
	a_set_end_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_set_end) |=> (state_q == ST_DRAIN) && (cnt_q == '0))
		else $error("set end did not start drain");
	a_last_ends_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(load && at_last) |=> (state_q == ST_FILL) && out_valid_q)
		else $error("drain did not finish on last rank");
	a_fill_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (cnt_q == '0))
		else $error("rank counter not clear in fill");

endmodule

`default_nettype wire

// ===== hw/rtl/top_n_insertion_sorter.sv =====
// Items are inserted into the ranks, one item per cycle while not unloading.
// On a set-end item the ranks are unloaded through the output register, one per
// cycle unless the output stalls: KEEP_COUNT results, the first valid once the
// controller is in drain and rank 0 is registered. Input stalls while unloading.
// Reset (arst_n low) clears all ranks to zero and clears out_valid.
// ----------------------------------------------------------------------------
// top_n_insertion_sorter
// Keeps the highest-pt objects of a set in descending order, emits on set end.
// ----------------------------------------------------------------------------
`default_nettype none

module top_n_insertion_sorter (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire tnis_pkg::obj_t in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output tnis_pkg::res_t      out_data
);
	import tnis_pkg::*;

	cmd_t cmd;

	tnis_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_set_end (in_data.set_end),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd)
	);

	tnis_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
